/* hdl/pobl_pkg.sv */
package pobl_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_MODIFY = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    localparam int POS_W   = 8;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 31;
    localparam int CNT_W   = 5;

    typedef struct packed {
        t_op                op;
        logic               pos_zero;
        logic [POS_W-1:0]   position;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   quantity;
    } t_cmd;

endpackage

/* hdl/pobl_front.sv */
module pobl_front (
    input  logic [1:0]     i_kind,
    input  logic [7:0]     i_position,
    input  logic [31:0]    i_price,
    input  logic [30:0]    i_quantity,
    output pobl_pkg::t_cmd o_cmd
);
    import pobl_pkg::*;

    logic pos_zero;

    assign pos_zero = (i_position == '0);

    always_comb begin
        o_cmd.op       = t_op'(i_kind);
        o_cmd.price    = i_price;
        o_cmd.quantity = i_quantity;
        o_cmd.pos_zero = pos_zero;
        o_cmd.position = i_position;
        // insert at position zero lands at the head
        if ((o_cmd.op == OP_INSERT) && pos_zero) begin
            o_cmd.position = POS_W'(1);
            o_cmd.pos_zero = 1'b0;
        end
    end

endmodule

/* hdl/pobl_queue.sv */
module pobl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pobl_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output pobl_pkg::t_cmd o_data,
    output logic           o_empty
);
    import pobl_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       n_wr_ptr;
    logic       n_rd_ptr;
    logic [1:0] n_fill;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ do_push;
        n_rd_ptr = r_rd_ptr ^ do_pop;
        n_fill   = r_fill + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_fill != 2'd3)
        else $error("queue fill out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == 2'd0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with fill");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_fill != 2'd0))
        else $error("pushed transaction lost");

endmodule

/* hdl/pobl_back.sv */
module pobl_back #(
    parameter int DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  pobl_pkg::t_cmd i_cmd,
    output logic           o_done,
    output logic [1:0]     o_status,
    output logic [4:0]     o_level_count,
    output logic [31:0]    o_level_price,
    output logic [30:0]    o_level_quantity
);
    import pobl_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);

    logic [CW-1:0]      r_count;
    logic [PRICE_W-1:0] r_price [DEPTH];
    logic [QTY_W-1:0]   r_qty   [DEPTH];
    logic               r_done;
    logic [1:0]         r_status;
    logic [CNT_W-1:0]   r_level_count;
    logic [PRICE_W-1:0] r_level_price;
    logic [QTY_W-1:0]   r_level_qty;

    logic [CW-1:0]      n_count;
    logic [PRICE_W-1:0] n_price [DEPTH];
    logic [QTY_W-1:0]   n_qty   [DEPTH];
    logic [1:0]         n_status;
    logic [PRICE_W-1:0] n_level_price;
    logic [QTY_W-1:0]   n_level_qty;

    logic [POS_W-1:0]   cnt8;
    logic [POS_W-1:0]   slot8;
    logic [IW-1:0]      rd_idx;
    logic               present;
    logic               full;
    logic               do_ins;
    logic               do_mod;
    logic               do_del;

    assign cnt8    = POS_W'(r_count);
    assign full    = (r_count == CW'(DEPTH));
    assign present = !i_cmd.pos_zero && (i_cmd.position <= cnt8);
    assign rd_idx  = slot8[IW-1:0];
    assign do_ins  = i_valid && (i_cmd.op == OP_INSERT) && !full;
    assign do_mod  = i_valid && (i_cmd.op == OP_MODIFY) && present;
    assign do_del  = i_valid && (i_cmd.op == OP_DELETE) && present;

    always_comb begin
        if ((i_cmd.op == OP_INSERT) && (i_cmd.position > cnt8)) begin
            slot8 = cnt8;
        end else begin
            slot8 = i_cmd.position - POS_W'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_price[i] = r_price[i];
            n_qty[i]   = r_qty[i];
            if (do_ins || do_mod) begin
                if (POS_W'(i) == slot8) begin
                    n_price[i] = i_cmd.price;
                    n_qty[i]   = i_cmd.quantity;
                end else if (do_ins && (POS_W'(i) > slot8) && (POS_W'(i) <= cnt8)) begin
                    if (i > 0) begin
                        n_price[i] = r_price[i-1];
                        n_qty[i]   = r_qty[i-1];
                    end
                end
            end else if (do_del) begin
                if ((POS_W'(i) >= slot8) && ((POS_W'(i) + POS_W'(1)) < cnt8)) begin
                    if (i < DEPTH - 1) begin
                        n_price[i] = r_price[i+1];
                        n_qty[i]   = r_qty[i+1];
                    end
                end
            end
        end
    end

    always_comb begin
        n_count       = r_count;
        n_status      = ST_OK;
        n_level_price = '0;
        n_level_qty   = '0;
        if (do_ins) begin
            n_count = r_count + CW'(1);
        end else if (do_del) begin
            n_count = r_count - CW'(1);
        end
        unique case (i_cmd.op)
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end
            end
            OP_MODIFY, OP_DELETE: begin
                if (!present) begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (present) begin
                    n_level_price = r_price[rd_idx];
                    n_level_qty   = r_qty[rd_idx];
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_price[i] <= n_price[i];
            r_qty[i]   <= n_qty[i];
        end
        if (i_valid) begin
            r_status      <= n_status;
            r_level_count <= CNT_W'(n_count);
            r_level_price <= n_level_price;
            r_level_qty   <= n_level_qty;
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_level_count    = r_level_count;
    assign o_level_price    = r_level_price;
    assign o_level_quantity = r_level_qty;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_count <= CW'(DEPTH))
        else $error("level count exceeds depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && (i_cmd.op == OP_INSERT) && full) |=> (r_status == ST_FULL))
        else $error("full insert not rejected");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |=> (r_count == $past(r_count)))
        else $error("count changed without a transaction");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (r_status != ST_OK)) |-> ((r_level_price == '0) && (r_level_qty == '0)))
        else $error("read data on a failed transaction");

endmodule

/* hdl/positional_order_book_levels.sv */
// A transaction accepted on start is registered in the command queue, then
// processed by the back end, which registers its result and strobes o_done.
// Throughput: one transaction per cycle; the level cells all shift together.
// busy rises only if the two-entry command queue fills, which the back end avoids.
// Reset (synchronous, active low) empties the book and the queue; level storage
// is not cleared. The receiver cannot stall: each result is shown for one cycle.
module positional_order_book_levels #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_price,
    input  logic [30:0] i_quantity,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [4:0]  o_level_count,
    output logic [31:0] o_level_price,
    output logic [30:0] o_level_quantity
);
    import pobl_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_full;
    logic q_empty;
    logic q_push;

    assign busy   = q_full;
    assign q_push = start && !q_full;

    pobl_front u_front (
        .i_kind     (i_kind),
        .i_position (i_position),
        .i_price    (i_price),
        .i_quantity (i_quantity),
        .o_cmd      (front_cmd)
    );

    pobl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (!q_empty),
        .o_data  (queue_cmd),
        .o_empty (q_empty)
    );

    pobl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!q_empty),
        .i_cmd            (queue_cmd),
        .o_done           (o_done),
        .o_status         (o_status),
        .o_level_count    (o_level_count),
        .o_level_price    (o_level_price),
        .o_level_quantity (o_level_quantity)
    );

endmodule

/* tb/pobl_level_checker.sv */
`timescale 1ns / 1ps

module pobl_level_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_position,
    input  logic [31:0] i_price,
    input  logic [30:0] i_quantity,
    input  logic        i_done,
    input  logic [1:0]  i_status,
    input  logic [4:0]  i_level_count,
    input  logic [31:0] i_level_price,
    input  logic [30:0] i_level_quantity,
    output int          o_pending,
    output int          o_errors
);
    import pobl_pkg::*;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0] quantity;
    } t_level_result;

    logic [PRICE_W-1:0] book_price [DEPTH];
    logic [QTY_W-1:0]   book_qty   [DEPTH];
    int                 book_count;
    t_level_result      expected_results [$];
    int                 error_count;

    function automatic t_level_result apply_command(t_op op, logic [7:0] pos,
                                                    logic [31:0] price,
                                                    logic [30:0] qty);
        t_level_result res;
        int            slot;
        int            k;
        res = '0;
        res.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (book_count >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    slot = (pos == 0) ? 0 : int'(pos) - 1;
                    if (slot > book_count) slot = book_count;
                    for (k = book_count; k > slot; k--) begin
                        book_price[k] = book_price[k-1];
                        book_qty[k]   = book_qty[k-1];
                    end
                    book_price[slot] = price;
                    book_qty[slot]   = qty;
                    book_count++;
                end
            end
            OP_MODIFY: begin
                if (pos >= 1 && pos <= book_count) begin
                    book_price[pos-1] = price;
                    book_qty[pos-1]   = qty;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            OP_DELETE: begin
                if (pos >= 1 && pos <= book_count) begin
                    for (k = int'(pos) - 1; k + 1 < book_count; k++) begin
                        book_price[k] = book_price[k+1];
                        book_qty[k]   = book_qty[k+1];
                    end
                    book_count--;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            default: begin
                if (pos >= 1 && pos <= book_count) begin
                    res.price    = book_price[pos-1];
                    res.quantity = book_qty[pos-1];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
        endcase
        res.count = book_count[CNT_W-1:0];
        return res;
    endfunction

    task automatic report(string field, logic [31:0] want, logic [31:0] got);
        error_count++;
        $display("%0t mismatch %s expected %0d actual %0d", $time, field, want, got);
    endtask

    initial begin
        book_count  = 0;
        error_count = 0;
        o_pending   = 0;
        o_errors    = 0;
    end

    always @(posedge i_clk) begin
        t_level_result want;
        if (!i_rst_n) begin
            book_count = 0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result transaction status %0d count %0d",
                             $time, i_status, i_level_count);
                end else begin
                    want = expected_results.pop_front();
                    if (i_status !== want.status)
                        report("status", want.status, i_status);
                    if (i_level_count !== want.count)
                        report("level_count", want.count, i_level_count);
                    if (i_level_price !== want.price)
                        report("level_price", want.price, i_level_price);
                    if (i_level_quantity !== want.quantity)
                        report("level_quantity", want.quantity, i_level_quantity);
                end
            end
            if (i_start && !i_busy)
                expected_results.push_back(apply_command(t_op'(i_kind), i_position,
                                                         i_price, i_quantity));
        end
        o_pending <= expected_results.size();
        o_errors  <= error_count;
    end

endmodule

/* tb/tb_positional_order_book_levels.sv */
`timescale 1ns / 1ps

module tb_positional_order_book_levels;
    import pobl_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_kind;
    logic [7:0]  i_position;
    logic [31:0] i_price;
    logic [30:0] i_quantity;
    logic        o_done;
    logic [1:0]  o_status;
    logic [4:0]  o_level_count;
    logic [31:0] o_level_price;
    logic [30:0] o_level_quantity;

    int          pending;
    int          errors;
    int          idle_cycles;
    logic        burst;

    positional_order_book_levels #(.DEPTH(DEPTH)) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_price         (i_price),
        .i_quantity      (i_quantity),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_level_count   (o_level_count),
        .o_level_price   (o_level_price),
        .o_level_quantity(o_level_quantity)
    );

    pobl_level_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_kind          (i_kind),
        .i_position      (i_position),
        .i_price         (i_price),
        .i_quantity      (i_quantity),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_level_count   (o_level_count),
        .i_level_price   (o_level_price),
        .i_level_quantity(o_level_quantity),
        .o_pending       (pending),
        .o_errors        (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (start && !busy && i_rst_n || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue(input t_op op, input logic [7:0] pos, input logic [31:0] price,
                         input logic [30:0] qty);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_kind     <= op;
        i_position <= pos;
        i_price    <= price;
        i_quantity <= qty;
        do @(posedge i_clk); while (busy);
    endtask

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return '0;
        if (roll == 1) return '1;
        return $urandom();
    endfunction

    initial begin
        int          n;
        int          mode;
        int          roll;
        t_op         op;
        logic [7:0]  pos;

        idle_cycles = 0;
        burst       = 1'b0;
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_kind     <= OP_READ;
        i_position <= '0;
        i_price    <= '0;
        i_quantity <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty book, insert clamps, shifts, miss cases
        issue(OP_READ,   8'd0,   '0, '0);
        issue(OP_READ,   8'd1,   '0, '0);
        issue(OP_MODIFY, 8'd1,   32'h1111_1111, 31'h1111_1111);
        issue(OP_DELETE, 8'd0,   '0, '0);
        issue(OP_INSERT, 8'd0,   '1, '1);
        issue(OP_INSERT, 8'd255, '0, '0);
        issue(OP_INSERT, 8'd2,   32'hA5A5_A5A5, 31'h5A5A_5A5A);
        issue(OP_READ,   8'd1,   '0, '0);
        issue(OP_READ,   8'd2,   '0, '0);
        issue(OP_READ,   8'd3,   '0, '0);
        issue(OP_READ,   8'd4,   '0, '0);
        issue(OP_MODIFY, 8'd0,   32'hDEAD_BEEF, 31'h0BAD_F00D);
        issue(OP_MODIFY, 8'd3,   32'h1234_5678, 31'h0246_8ACE);
        issue(OP_READ,   8'd3,   '0, '0);
        issue(OP_DELETE, 8'd2,   '0, '0);
        issue(OP_READ,   8'd2,   '0, '0);
        issue(OP_DELETE, 8'd255, '0, '0);
        issue(OP_DELETE, 8'd1,   '0, '0);
        issue(OP_DELETE, 8'd1,   '0, '0);
        issue(OP_READ,   8'd1,   '0, '0);

        mode = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) mode = $urandom_range(0, 3);
            if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
            roll = $urandom_range(0, 99);
            case (mode)
                0: op = roll < 55 ? OP_INSERT : roll < 70 ? OP_MODIFY :
                        roll < 80 ? OP_DELETE : OP_READ;
                1: op = roll < 15 ? OP_INSERT : roll < 30 ? OP_MODIFY :
                        roll < 75 ? OP_DELETE : OP_READ;
                2: op = roll < 30 ? OP_INSERT : roll < 50 ? OP_MODIFY :
                        roll < 80 ? OP_DELETE : OP_READ;
                default: op = roll < 20 ? OP_INSERT : roll < 35 ? OP_MODIFY :
                              roll < 50 ? OP_DELETE : OP_READ;
            endcase
            pos = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, DEPTH + 1));
            issue(op, pos, pick_value(), 31'(pick_value()));
        end

        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
